>>> src/nfa_wa_pkg.sv
package nfa_wa_pkg;

  // defaults for the top-level parameters
  localparam int DEF_NUM_STATES  = 16;
  localparam int DEF_NUM_SYMBOLS = 256;

  // fixed field widths
  localparam int REQ_W        = 2;
  localparam int STATE_IDX_W  = 4;
  localparam int SYMBOL_W     = 8;
  localparam int ACTIVE_W     = 16;
  localparam int FINAL_W      = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  // compare widths: hold any field value and the largest parameter value
  localparam int STATE_CMP_W  = 7;
  localparam int SYMBOL_CMP_W = 9;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FEED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 1'b1;

  typedef struct packed {
    logic load_req;   // capture request, zero counter and accumulator
    logic inc_cnt;    // advance counter
    logic sweep_wr;   // write zero at counter address
    logic rd_add;     // read mask at request address
    logic wr_add;     // write merged mask at request address
    logic rd_feed;    // read mask of counter state for request symbol
    logic load_out;   // update active set and load result register
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last; // counter at last store address
    logic state_last; // counter at last state index
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

>>> src/nfa_wa_in_if.sv
interface nfa_wa_in_if;
  logic                                valid;
  logic                                ready;
  logic [nfa_wa_pkg::REQ_W-1:0]        req_type;
  logic [nfa_wa_pkg::STATE_IDX_W-1:0]  from_state;
  logic [nfa_wa_pkg::STATE_IDX_W-1:0]  to_state;
  logic [nfa_wa_pkg::SYMBOL_W-1:0]     symbol;

  modport source (output valid, output req_type, output from_state, output to_state,
                  output symbol, input ready);
  modport sink   (input valid, input req_type, input from_state, input to_state,
                  input symbol, output ready);
endinterface

>>> src/nfa_wa_out_if.sv
interface nfa_wa_out_if;
  logic                             valid;
  logic                             ready;
  logic [nfa_wa_pkg::ACTIVE_W-1:0]  active_states;
  logic                             accepted;
  logic                             no_active;

  modport source (output valid, output active_states, output accepted, output no_active,
                  input ready);
  modport sink   (input valid, input active_states, input accepted, input no_active,
                  output ready);
endinterface

>>> src/nfa_wa_ram.sv
module nfa_wa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/nfa_wa_ctrl.sv
module nfa_wa_ctrl import nfa_wa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] req_type,
  output logic             in_ready,
  output dp_cmd_t          cmd,
  input  dp_status_t       status
);

  localparam logic [2:0] ST_SWEEP_RST = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_SWEEP     = 3'd2;
  localparam logic [2:0] ST_ADD_RD    = 3'd3;
  localparam logic [2:0] ST_ADD_WR    = 3'd4;
  localparam logic [2:0] ST_FEED_RD   = 3'd5;
  localparam logic [2:0] ST_FEED_END  = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP_RST;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_SWEEP_RST: begin
        cmd.sweep_wr = 1'b1;
        cmd.inc_cnt  = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          case (req_type)
            REQ_CLEAR: state_next = ST_SWEEP;
            REQ_ADD:   state_next = ST_ADD_RD;
            REQ_START: state_next = ST_DONE;
            REQ_FEED:  state_next = ST_FEED_RD;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        cmd.inc_cnt  = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_ADD_RD: begin
        cmd.rd_add = 1'b1;
        state_next = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.wr_add = 1'b1;
        state_next = ST_DONE;
      end
      ST_FEED_RD: begin
        cmd.rd_feed = 1'b1;
        cmd.inc_cnt = 1'b1;
        if (status.state_last) begin
          state_next = ST_FEED_END;
        end
      end
      ST_FEED_END: begin
        // last read data is folded in at the end of this cycle
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/nfa_wa_datapath.sv
module nfa_wa_datapath import nfa_wa_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [REQ_W-1:0]       req_type,
  input  logic [STATE_IDX_W-1:0] from_state,
  input  logic [STATE_IDX_W-1:0] to_state,
  input  logic [SYMBOL_W-1:0]    symbol,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [ACTIVE_W-1:0]    active_states,
  output logic                   accepted,
  output logic                   no_active
);

  localparam int ST_W   = $clog2(NUM_STATES);
  localparam int SYM_W  = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W = ST_W + SYM_W;
  localparam int DEPTH  = NUM_STATES * (2 ** SYM_W);

  // captured request
  logic [REQ_W-1:0]       cur_req;
  logic [STATE_IDX_W-1:0] cur_from;
  logic [STATE_IDX_W-1:0] cur_to;
  logic [SYMBOL_W-1:0]    cur_sym;

  // configuration
  logic [STATE_IDX_W-1:0] initial_state;
  logic [FINAL_W-1:0]     final_mask;

  logic [NUM_STATES-1:0]  active_set;
  logic [NUM_STATES-1:0]  acc;
  logic [ADDR_W-1:0]      cnt;
  logic                   feed_vld;
  logic [ST_W-1:0]        feed_idx;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [NUM_STATES-1:0]  mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [NUM_STATES-1:0]  mem_rdata;

  logic                   from_ok;
  logic                   to_ok;
  logic                   sym_ok;
  logic                   init_ok;
  logic                   add_ok;
  logic [ADDR_W-1:0]      req_addr;
  logic [NUM_STATES-1:0]  one_hot0;
  logic [NUM_STATES-1:0]  to_bit;
  logic [NUM_STATES-1:0]  start_set;
  logic [NUM_STATES-1:0]  act_new;
  logic [NUM_STATES+ACTIVE_W-1:0] act_wide;
  logic [ACTIVE_W-1:0]    act_lo;

  assign from_ok = STATE_CMP_W'(cur_from) < STATE_CMP_W'(NUM_STATES);
  assign to_ok   = STATE_CMP_W'(cur_to) < STATE_CMP_W'(NUM_STATES);
  assign sym_ok  = SYMBOL_CMP_W'(cur_sym) < SYMBOL_CMP_W'(NUM_SYMBOLS);
  assign init_ok = STATE_CMP_W'(initial_state) < STATE_CMP_W'(NUM_STATES);
  assign add_ok  = from_ok && to_ok && sym_ok;

  assign req_addr  = {ST_W'(cur_from), SYM_W'(cur_sym)};
  assign one_hot0  = {{(NUM_STATES-1){1'b0}}, 1'b1};
  assign to_bit    = one_hot0 << cur_to;
  assign start_set = init_ok ? (one_hot0 << initial_state) : '0;

  always_comb begin
    case (cur_req)
      REQ_START: act_new = start_set;
      REQ_FEED:  act_new = sym_ok ? acc : '0;
      default:   act_new = active_set;
    endcase
  end

  assign act_wide = {{ACTIVE_W{1'b0}}, act_new};
  assign act_lo   = act_wide[ACTIVE_W-1:0];

  // transition store port muxing
  assign mem_we    = cmd.sweep_wr || (cmd.wr_add && add_ok);
  assign mem_waddr = cmd.sweep_wr ? cnt : req_addr;
  assign mem_wdata = cmd.sweep_wr ? '0 : (mem_rdata | to_bit);
  assign mem_raddr = cmd.rd_feed ? {cnt[ST_W-1:0], SYM_W'(cur_sym)} : req_addr;

  nfa_wa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign status.sweep_last = (cnt == ADDR_W'(DEPTH - 1));
  assign status.state_last = (cnt[ST_W-1:0] == ST_W'(NUM_STATES - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur_req  <= req_type;
      cur_from <= from_state;
      cur_to   <= to_state;
      cur_sym  <= symbol;
    end
    feed_idx <= cnt[ST_W-1:0];
    if (cmd.load_req) begin
      acc <= '0;
    end else if (feed_vld && active_set[feed_idx]) begin
      acc <= acc | mem_rdata;
    end
    if (cmd.load_out) begin
      active_states <= act_lo;
      accepted      <= |(act_lo & final_mask);
      no_active     <= (act_new == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      feed_vld      <= 1'b0;
      out_valid     <= 1'b0;
      active_set    <= '0;
      initial_state <= '0;
      final_mask    <= '0;
    end else begin
      if (cmd.load_req) begin
        cnt <= '0;
      end else if (cmd.inc_cnt) begin
        cnt <= cnt + ADDR_W'(1);
      end
      feed_vld <= cmd.rd_feed;
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        active_set <= act_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_STATE: initial_state <= cfg_data[STATE_IDX_W-1:0];
          CFG_FINAL_MASK:    final_mask    <= cfg_data[FINAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> src/nfa_word_acceptor_unit.sv
// Channel   | Dir | Handshake        | Payload
// request   | in  | valid / ready    | req_type, from_state, to_state, symbol
// result    | out | valid / ready    | active_states, accepted, no_active
// cfg       | in  | cfg_we           | cfg_index, cfg_data
//
// One request transaction at a time; ready is high only while the controller is idle.
// Steps per transaction: start word goes from the accept to the result load; add transition
// reads and writes back one store entry; feed symbol does one store read per state through
// the single read port; clear table zeroes the whole store, one entry per cycle.
// After reset the whole store is swept to zero with request ready low. A stalled result
// waits in the output register; the next request is still accepted and runs up to its
// result load.
module nfa_word_acceptor_unit import nfa_wa_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic                  clk,
  input  logic                  rst,
  nfa_wa_in_if.sink             request,
  nfa_wa_out_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: sequences the store sweeps, read-modify-write and state scan
  nfa_wa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .req_type (request.req_type),
    .in_ready (request.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath: transition store, active set, accumulator, result register
  nfa_wa_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (request.req_type),
    .from_state    (request.from_state),
    .to_state      (request.to_state),
    .symbol        (request.symbol),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .active_states (result.active_states),
    .accepted      (result.accepted),
    .no_active     (result.no_active)
  );

endmodule
